@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion violated");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion violated");

`endif

@@ rtl/pvag_pkg.sv @@
// ----------------------------------------------------------------------------
// pvag_pkg
// Shared codes, types and format helpers of the packet peak activity gate.
// ----------------------------------------------------------------------------
package pvag_pkg;

  localparam logic [1:0] SIZE_8  = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_32 = 2'd2;

  localparam logic [1:0] KIND_UNSIGNED = 2'd0;
  localparam logic [1:0] KIND_SIGNED   = 2'd1;
  localparam logic [1:0] KIND_FLOAT    = 2'd2;

  localparam logic [2:0] REG_SIZE      = 3'd0;
  localparam logic [2:0] REG_KIND      = 3'd1;
  localparam logic [2:0] REG_BIG_END   = 3'd2;
  localparam logic [2:0] REG_ENABLE    = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_TIMEOUT   = 3'd5;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  localparam int ADDR_W  = 5;
  localparam int THR_W   = 17;
  localparam int PROD_W  = 49;
  localparam int TUSER_W = 6;

  localparam int U_LEVEL_HIGH  = 0;
  localparam int U_LEVEL_CHG   = 1;
  localparam int U_PEAK_CHG    = 2;
  localparam int U_ACTIVE      = 3;
  localparam int U_BEGAN       = 4;
  localparam int U_ENDED       = 5;

  localparam logic [31:0] HOLD_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0] size;
    logic [1:0] kind;
    logic       big_endian;
  } fmt_t;

  // full scale of a format, zero when the format is unsupported
  function automatic logic [31:0] full_scale(input fmt_t f);
    logic [31:0] fs;
    fs = 32'd0;
    case (f.size)
      SIZE_8: begin
        if (f.kind == KIND_UNSIGNED) fs = 32'd255;
        else if (f.kind == KIND_SIGNED) fs = 32'd127;
      end
      SIZE_16: begin
        if (f.kind == KIND_UNSIGNED) fs = 32'd65535;
        else if (f.kind == KIND_SIGNED) fs = 32'd32767;
      end
      SIZE_32: begin
        if (f.kind == KIND_UNSIGNED) fs = 32'hffff_ffff;
        else if (f.kind == KIND_SIGNED || f.kind == KIND_FLOAT) fs = 32'h7fff_ffff;
      end
      default: fs = 32'd0;
    endcase
    return fs;
  endfunction

  // full scale is 2^k - 1 for every supported format
  function automatic logic [5:0] scale_shift(input fmt_t f);
    logic [5:0] k;
    k = 6'd0;
    case (f.size)
      SIZE_8:  k = (f.kind == KIND_UNSIGNED) ? 6'd8 : 6'd7;
      SIZE_16: k = (f.kind == KIND_UNSIGNED) ? 6'd16 : 6'd15;
      SIZE_32: k = (f.kind == KIND_UNSIGNED) ? 6'd32 : 6'd31;
      default: k = 6'd0;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/pvag_decode.sv @@
// ----------------------------------------------------------------------------
// pvag_decode
// Turns one sample word into an unsigned magnitude for the configured format.
// ----------------------------------------------------------------------------
module pvag_decode (
  input  pvag_pkg::fmt_t fmt_i,
  input  logic [31:0]    bytes_i,
  output logic [31:0]    mag_o
);

  logic [15:0] v16;
  logic [31:0] v32;
  logic [8:0]  mag8;
  logic [16:0] mag16;
  logic [31:0] mag32;
  logic [31:0] fmag;
  logic [7:0]  fexp;
  logic [23:0] fman;
  logic [7:0]  sh_up;
  logic [7:0]  sh_dn;

  assign v16 = fmt_i.big_endian ? {bytes_i[7:0], bytes_i[15:8]} : bytes_i[15:0];
  assign v32 = fmt_i.big_endian ?
               {bytes_i[7:0], bytes_i[15:8], bytes_i[23:16], bytes_i[31:24]} : bytes_i;

  assign mag8 = (fmt_i.kind == pvag_pkg::KIND_SIGNED && bytes_i[7]) ?
                (9'h100 - {1'b0, bytes_i[7:0]}) : {1'b0, bytes_i[7:0]};
  assign mag16 = (fmt_i.kind == pvag_pkg::KIND_SIGNED && v16[15]) ?
                 (17'h10000 - {1'b0, v16}) : {1'b0, v16};
  assign mag32 = (fmt_i.kind == pvag_pkg::KIND_SIGNED && v32[31]) ? (32'd0 - v32) : v32;

  // float magnitude scaled by 2^31
  assign fexp  = v32[30:23];
  assign fman  = {1'b1, v32[22:0]};
  assign sh_up = fexp - 8'd119;
  assign sh_dn = 8'd119 - fexp;

  always_comb begin
    if (fexp == 8'd255) begin
      fmag = 32'hffff_ffff;
    end else if (fexp == 8'd0) begin
      fmag = 32'd0;
    end else if (fexp >= 8'd119) begin
      if (sh_up > 8'd8) fmag = 32'hffff_ffff;
      else fmag = {8'd0, fman} << sh_up[3:0];
    end else begin
      if (sh_dn >= 8'd24) fmag = 32'd0;
      else fmag = {8'd0, fman} >> sh_dn[4:0];
    end
  end

  always_comb begin
    case (fmt_i.size)
      pvag_pkg::SIZE_8:  mag_o = {23'd0, mag8};
      pvag_pkg::SIZE_16: mag_o = {15'd0, mag16};
      default: mag_o = (fmt_i.kind == pvag_pkg::KIND_FLOAT) ? fmag : mag32;
    endcase
  end

endmodule

@@ rtl/packet_peak_voice_activity_gate_unit.sv @@
// ----------------------------------------------------------------------------
// packet_peak_voice_activity_gate_unit
// Result path: a packet-end sample is held in the input register, then its
//   result is loaded into the result register.
// Throughput: one item per cycle; the input register waits only when a
//   packet result meets a full, stalled output register.
// Reset: asynchronous, clears control and all gate state, registers to defaults.
// ----------------------------------------------------------------------------
module packet_peak_voice_activity_gate_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // stream in
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,   // sample_bytes
  input  logic                               s_tuser,   // command
  input  logic                               s_tlast,   // last_of_packet
  // stream out
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [31:0]                        m_tdata,   // packet_peak
  // level_high, level_changed, peak_changed, voice_active, activity_began,
  // activity_ended
  output logic [pvag_pkg::TUSER_W-1:0]       m_tuser,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pvag_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  pvag_pkg::fmt_t                 fmt_q;
  logic                           enable_q;
  logic [pvag_pkg::THR_W-1:0]     thr_q;
  logic [31:0]                    timeout_q;

  logic                           s1_valid_q;
  logic                           s1_cmd_q;
  logic [31:0]                    s1_bytes_q;
  logic                           s1_last_q;

  logic [31:0]                    run_q;
  logic [31:0]                    prev_q;
  logic [31:0]                    hold_q;
  logic                           active_q;
  logic                           level_q;

  logic                           m_valid_q;
  logic [31:0]                    m_data_q;
  logic [pvag_pkg::TUSER_W-1:0]   m_user_q;

  logic                           cfg_wr;
  logic [2:0]                     cfg_idx;
  logic [31:0]                    fs;
  logic [5:0]                     fs_k;
  logic                           usable;
  logic [31:0]                    mag;
  logic [31:0]                    peak_run;
  logic [31:0]                    peak;
  logic [pvag_pkg::PROD_W-1:0]    thr_ext;
  logic [pvag_pkg::PROD_W-1:0]    thr_fs;
  logic [pvag_pkg::PROD_W-1:0]    peak_ext;
  logic                           high;
  logic                           is_sample;
  logic                           emits;
  logic                           out_free;
  logic                           process;
  logic                           active_d;
  logic                           began;
  logic                           ended;
  logic [pvag_pkg::TUSER_W-1:0]   user_d;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_comb begin
    case (cfg_idx)
      pvag_pkg::REG_SIZE:      prdata = {30'd0, fmt_q.size};
      pvag_pkg::REG_KIND:      prdata = {30'd0, fmt_q.kind};
      pvag_pkg::REG_BIG_END:   prdata = {31'd0, fmt_q.big_endian};
      pvag_pkg::REG_ENABLE:    prdata = {31'd0, enable_q};
      pvag_pkg::REG_THRESHOLD: prdata = {15'd0, thr_q};
      pvag_pkg::REG_TIMEOUT:   prdata = timeout_q;
      default:                 prdata = 32'd0;
    endcase
  end

  // datapath
  assign fs     = pvag_pkg::full_scale(fmt_q);
  assign fs_k   = pvag_pkg::scale_shift(fmt_q);
  assign usable = enable_q & (fs != 32'd0);

  pvag_decode u_decode (
    .fmt_i   (fmt_q),
    .bytes_i (s1_bytes_q),
    .mag_o   (mag)
  );

  assign peak_run = (mag > run_q) ? mag : run_q;
  assign peak     = (peak_run < fs) ? peak_run : fs;

  // threshold * (2^k - 1) as shift and subtract
  assign thr_ext  = {{(pvag_pkg::PROD_W-pvag_pkg::THR_W){1'b0}}, thr_q};
  assign thr_fs   = (thr_ext << fs_k) - thr_ext;
  assign peak_ext = {1'b0, peak, 16'd0};
  assign high     = peak_ext > thr_fs;

  assign began    = high & ~active_q;
  assign ended    = ~high & active_q & (hold_q >= timeout_q);
  assign active_d = high | (active_q & ~ended);

  always_comb begin
    user_d = '0;
    user_d[pvag_pkg::U_LEVEL_HIGH] = high;
    user_d[pvag_pkg::U_LEVEL_CHG]  = high ^ level_q;
    user_d[pvag_pkg::U_PEAK_CHG]   = peak != prev_q;
    user_d[pvag_pkg::U_ACTIVE]     = active_d;
    user_d[pvag_pkg::U_BEGAN]      = began;
    user_d[pvag_pkg::U_ENDED]      = ended;
  end

  // flow control
  assign is_sample = s1_cmd_q == pvag_pkg::CMD_SAMPLE;
  assign emits     = s1_valid_q & is_sample & usable & s1_last_q;
  assign out_free  = ~m_valid_q | m_tready;
  assign process   = s1_valid_q & (~emits | out_free);
  assign s_tready  = ~s1_valid_q | process;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_tready) begin
      s1_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      s1_cmd_q   <= s_tuser;
      s1_bytes_q <= s_tdata;
      s1_last_q  <= s_tlast;
    end
  end

  // configuration and gate state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q.size       <= pvag_pkg::SIZE_16;
      fmt_q.kind       <= pvag_pkg::KIND_SIGNED;
      fmt_q.big_endian <= 1'b0;
      enable_q         <= 1'b0;
      thr_q            <= 17'd6554;
      timeout_q        <= 32'd1000;
      run_q            <= 32'd0;
      prev_q           <= 32'd0;
      hold_q           <= 32'd0;
      active_q         <= 1'b0;
      level_q          <= 1'b0;
    end else begin
      if (process) begin
        if (!is_sample) begin
          if (hold_q != pvag_pkg::HOLD_MAX) hold_q <= hold_q + 32'd1;
        end else if (!usable) begin
          run_q <= 32'd0;
        end else if (!s1_last_q) begin
          run_q <= peak_run;
        end else begin
          run_q    <= 32'd0;
          prev_q   <= peak;
          level_q  <= high;
          active_q <= active_d;
          if (high) hold_q <= 32'd0;
        end
      end
      if (cfg_wr) begin
        case (cfg_idx)
          pvag_pkg::REG_SIZE:      fmt_q.size       <= pwdata[1:0];
          pvag_pkg::REG_KIND:      fmt_q.kind       <= pwdata[1:0];
          pvag_pkg::REG_BIG_END:   fmt_q.big_endian <= pwdata[0];
          pvag_pkg::REG_ENABLE: begin
            enable_q <= pwdata[0];
            if (!pwdata[0]) begin
              active_q <= 1'b0;
              run_q    <= 32'd0;
            end
          end
          pvag_pkg::REG_THRESHOLD: thr_q     <= pwdata[pvag_pkg::THR_W-1:0];
          pvag_pkg::REG_TIMEOUT:   timeout_q <= pwdata;
          default: ;
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (process && emits) begin
      m_valid_q <= 1'b1;
    end else if (m_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (process && emits) begin
      m_data_q <= peak;
      m_user_q <= user_d;
    end
  end

  assign m_tvalid = m_valid_q;
  assign m_tdata  = m_data_q;
  assign m_tuser  = m_user_q;

endmodule

@@ rtl/pvag_checker.sv @@
// ----------------------------------------------------------------------------
// pvag_checker
// Port-level checks of the activity gate, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pvag_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [31:0]                  m_tdata,
  input logic [pvag_pkg::TUSER_W-1:0] m_tuser
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `ASSERT_IMPLIES(a_high_active, clk_i, rst_ni, m_tvalid && m_tuser[pvag_pkg::U_LEVEL_HIGH], m_tuser[pvag_pkg::U_ACTIVE])
  `ASSERT_IMPLIES(a_began, clk_i, rst_ni, m_tvalid && m_tuser[pvag_pkg::U_BEGAN], m_tuser[pvag_pkg::U_ACTIVE] && m_tuser[pvag_pkg::U_LEVEL_HIGH])
  `ASSERT_IMPLIES(a_ended, clk_i, rst_ni, m_tvalid && m_tuser[pvag_pkg::U_ENDED], !m_tuser[pvag_pkg::U_ACTIVE] && !m_tuser[pvag_pkg::U_LEVEL_HIGH])

endmodule

bind packet_peak_voice_activity_gate_unit pvag_checker u_pvag_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/tb_packet_peak_voice_activity_gate_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_peak_voice_activity_gate_unit
// Self-checking bench for the packet peak voice activity gate. Samples and
// ticks stream in with random gaps, packet results stream out under random
// backpressure, and each result is compared field by field against a local
// model of decode, peak tracking, threshold and hold-off. Formats, threshold
// and timeout are reprogrammed over APB between traffic phases.
// ----------------------------------------------------------------------------
module tb_packet_peak_voice_activity_gate_unit;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam logic [1:0] SIZE_UNSUPPORTED = 2'd3;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [31:0] bytes;
    logic        last;
  } audio_item_t;

  typedef struct packed {
    logic [31:0] peak;
    logic        high;
    logic        level_chg;
    logic        peak_chg;
    logic        active;
    logic        began;
    logic        ended;
  } gate_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [31:0]                   s_tdata = '0;   // sample_bytes
  logic                          s_tuser = 1'b0; // command
  logic                          s_tlast = 1'b0; // last_of_packet
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;        // packet_peak
  // level_high, level_changed, peak_changed, voice_active, activity_began,
  // activity_ended
  logic [pvag_pkg::TUSER_W-1:0]  m_tuser;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [pvag_pkg::ADDR_W-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  packet_peak_voice_activity_gate_unit dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk_i = ~clk_i;

  // model configuration and state
  logic [1:0]                 cfg_size = pvag_pkg::SIZE_16;
  logic [1:0]                 cfg_kind = pvag_pkg::KIND_SIGNED;
  logic                       cfg_be = 1'b0;
  logic                       cfg_en = 1'b0;
  logic [pvag_pkg::THR_W-1:0] cfg_thr = 17'd6554;
  logic [31:0]                cfg_timeout = 32'd1000;
  logic [31:0]                run_peak = '0;
  logic [31:0]                last_peak = '0;
  logic [31:0]                hold_cnt = '0;
  logic                       vad_on = 1'b0;
  logic                       lvl_on = 1'b0;

  audio_item_t  sample_q[$];
  gate_report_t peak_reports_q[$];
  audio_item_t  cur_item;
  gate_report_t exp_r;
  logic         src_busy = 1'b0;
  int           src_idle_pct = 38;
  int           snk_idle_pct = 47;
  int           errors = 0;
  int           cycles = 0;

  function automatic logic [31:0] scale_of_format();
    logic [31:0] fs;
    fs = '0;
    if (cfg_size == pvag_pkg::SIZE_8) begin
      if (cfg_kind == pvag_pkg::KIND_UNSIGNED) fs = 32'd255;
      else if (cfg_kind == pvag_pkg::KIND_SIGNED) fs = 32'd127;
    end else if (cfg_size == pvag_pkg::SIZE_16) begin
      if (cfg_kind == pvag_pkg::KIND_UNSIGNED) fs = 32'd65535;
      else if (cfg_kind == pvag_pkg::KIND_SIGNED) fs = 32'd32767;
    end else if (cfg_size == pvag_pkg::SIZE_32) begin
      if (cfg_kind == pvag_pkg::KIND_UNSIGNED) fs = 32'hffff_ffff;
      else if (cfg_kind == pvag_pkg::KIND_SIGNED || cfg_kind == pvag_pkg::KIND_FLOAT)
        fs = 32'h7fff_ffff;
    end
    return fs;
  endfunction

  // |f| * 2^31, truncated, saturating
  function automatic logic [31:0] float_to_mag(input logic [31:0] w);
    logic [7:0]  e;
    logic [31:0] m;
    e = w[30:23];
    m = {8'h01, w[22:0]};
    if (e == 8'hff) return 32'hffff_ffff;
    if (e == 8'h00) return 32'd0;
    if (e >= 8'd119) begin
      if (e - 8'd119 > 8'd8) return 32'hffff_ffff;
      return m << (e - 8'd119);
    end
    if (8'd119 - e >= 8'd24) return 32'd0;
    return m >> (8'd119 - e);
  endfunction

  function automatic logic [31:0] sample_mag(input logic [31:0] b);
    logic [31:0] v;
    if (cfg_size == pvag_pkg::SIZE_8) begin
      v = {24'd0, b[7:0]};
      if (cfg_kind == pvag_pkg::KIND_SIGNED && v[7]) v = 32'd256 - v;
      return v;
    end
    if (cfg_size == pvag_pkg::SIZE_16) begin
      v = cfg_be ? {16'd0, b[7:0], b[15:8]} : {16'd0, b[15:0]};
      if (cfg_kind == pvag_pkg::KIND_SIGNED && v[15]) v = 32'h1_0000 - v;
      return v;
    end
    v = cfg_be ? {b[7:0], b[15:8], b[23:16], b[31:24]} : b;
    if (cfg_kind == pvag_pkg::KIND_FLOAT) return float_to_mag(v);
    if (cfg_kind == pvag_pkg::KIND_SIGNED && v[31]) v = -v;
    return v;
  endfunction

  function automatic void gate_predict(input audio_item_t it);
    logic [31:0]                 fs;
    logic [31:0]                 mag;
    logic [31:0]                 peak;
    logic [pvag_pkg::PROD_W-1:0] lhs;
    logic [pvag_pkg::PROD_W-1:0] rhs;
    gate_report_t                r;
    if (it.cmd == pvag_pkg::CMD_TICK) begin
      if (hold_cnt != pvag_pkg::HOLD_MAX) hold_cnt = hold_cnt + 1;
      return;
    end
    fs = scale_of_format();
    if (!cfg_en || fs == 0) begin
      run_peak = '0;
      return;
    end
    mag = sample_mag(it.bytes);
    if (mag > run_peak) run_peak = mag;
    if (!it.last) return;
    peak = (run_peak < fs) ? run_peak : fs;
    run_peak = '0;
    lhs = pvag_pkg::PROD_W'(peak) << 16;
    rhs = pvag_pkg::PROD_W'(cfg_thr) * pvag_pkg::PROD_W'(fs);
    r = '0;
    r.peak = peak;
    r.high = lhs > rhs;
    r.level_chg = r.high != lvl_on;
    r.peak_chg = peak != last_peak;
    lvl_on = r.high;
    last_peak = peak;
    if (r.high) begin
      hold_cnt = '0;
      if (!vad_on) begin
        vad_on = 1'b1;
        r.began = 1'b1;
      end
    end else if (vad_on && hold_cnt >= cfg_timeout) begin
      vad_on = 1'b0;
      r.ended = 1'b1;
    end
    r.active = vad_on;
    peak_reports_q.push_back(r);
  endfunction

  // random sample word for the current format, unused bytes filled with noise
  function automatic logic [31:0] make_sample_word();
    logic [31:0] raw;
    logic [31:0] v;
    logic [31:0] keep;
    int          bits;
    raw = $urandom;
    bits = (cfg_size == pvag_pkg::SIZE_8) ? 8 : (cfg_size == pvag_pkg::SIZE_16) ? 16 : 32;
    keep = (bits == 32) ? 32'hffff_ffff : ((32'd1 << bits) - 1);
    if (cfg_size == pvag_pkg::SIZE_32 && cfg_kind == pvag_pkg::KIND_FLOAT) begin
      case ($urandom_range(0, 9))
        0: v = {raw[31], 8'hff, raw[22:0]};
        1: v = {raw[31], 8'h00, raw[22:0]};
        default: v = {raw[31], 8'($urandom_range(96, 160)), raw[22:0]};
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0: v = 32'd1 << (bits - 1);
        1: v = 32'hffff_ffff;
        default: begin
          v = raw >> (32 - bits + $urandom_range(0, bits));
          if ($urandom_range(0, 1)) v = ~v;
        end
      endcase
    end
    v = v & keep;
    if (cfg_be && bits == 16) v = {16'd0, v[7:0], v[15:8]};
    else if (cfg_be && bits == 32) v = {v[7:0], v[15:8], v[23:16], v[31:24]};
    return (32'($urandom) & ~keep) | v;
  endfunction

  task automatic push_item(input logic cmd, input logic [31:0] bytes, input logic last);
    audio_item_t it;
    it.cmd = cmd;
    it.bytes = bytes;
    it.last = last;
    sample_q.push_back(it);
  endtask

  task automatic gen_traffic(input int n);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 8)) begin
            push_item(pvag_pkg::CMD_TICK, $urandom, 1'($urandom));
            cnt++;
          end
        end
        push_item(pvag_pkg::CMD_SAMPLE, make_sample_word(), i == len - 1);
        cnt++;
      end
    end
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || src_busy || peak_reports_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pvag_pkg::REG_SIZE:      cfg_size = val[1:0];
      pvag_pkg::REG_KIND:      cfg_kind = val[1:0];
      pvag_pkg::REG_BIG_END:   cfg_be = val[0];
      pvag_pkg::REG_ENABLE: begin
        cfg_en = val[0];
        if (!cfg_en) begin
          vad_on = 1'b0;
          run_peak = '0;
        end
      end
      pvag_pkg::REG_THRESHOLD: cfg_thr = val[pvag_pkg::THR_W-1:0];
      pvag_pkg::REG_TIMEOUT:   cfg_timeout = val;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        gate_predict(cur_item);
        src_busy = 1'b0;
      end
      if (!src_busy) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_item = sample_q.pop_front();
          src_busy = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata <= cur_item.bytes;
          s_tuser <= cur_item.cmd;
          s_tlast <= cur_item.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (peak_reports_q.size() == 0) begin
          $error("unexpected transfer: packet_peak %0h", m_tdata);
          errors++;
        end else begin
          exp_r = peak_reports_q.pop_front();
          check_field("packet_peak", exp_r.peak, m_tdata);
          check_field("level_high", exp_r.high, m_tuser[pvag_pkg::U_LEVEL_HIGH]);
          check_field("level_changed", exp_r.level_chg, m_tuser[pvag_pkg::U_LEVEL_CHG]);
          check_field("peak_changed", exp_r.peak_chg, m_tuser[pvag_pkg::U_PEAK_CHG]);
          check_field("voice_active", exp_r.active, m_tuser[pvag_pkg::U_ACTIVE]);
          check_field("activity_began", exp_r.began, m_tuser[pvag_pkg::U_BEGAN]);
          check_field("activity_ended", exp_r.ended, m_tuser[pvag_pkg::U_ENDED]);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL packet_peak_voice_activity_gate_unit");
      $finish;
    end
  end

  initial begin
    int p;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // disabled gate drops samples
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_7fff, 1'b1);
    push_item(pvag_pkg::CMD_TICK, 32'h0, 1'b0);
    set_reg(pvag_pkg::REG_ENABLE, 32'd1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_8000, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'habcd_0001, 1'b1);
    push_item(pvag_pkg::CMD_TICK, 32'hffff_ffff, 1'b1);
    push_item(pvag_pkg::CMD_TICK, 32'h0, 1'b0);
    set_reg(pvag_pkg::REG_TIMEOUT, 32'd0);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_0003, 1'b1);
    set_reg(pvag_pkg::REG_SIZE, pvag_pkg::SIZE_8);
    set_reg(pvag_pkg::REG_KIND, pvag_pkg::KIND_SIGNED);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h1234_5680, 1'b1);
    set_reg(pvag_pkg::REG_KIND, pvag_pkg::KIND_UNSIGNED);
    // packet stays open across a format change
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_00ff, 1'b0);
    set_reg(pvag_pkg::REG_SIZE, pvag_pkg::SIZE_32);
    set_reg(pvag_pkg::REG_KIND, pvag_pkg::KIND_FLOAT);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h3f80_0000, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h7f80_0000, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'hffc0_0001, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_0001, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h8000_0000, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h4f80_0000, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h3b00_0000, 1'b1);
    set_reg(pvag_pkg::REG_BIG_END, 32'd1);
    set_reg(pvag_pkg::REG_KIND, pvag_pkg::KIND_SIGNED);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_0080, 1'b1);
    set_reg(pvag_pkg::REG_KIND, pvag_pkg::KIND_UNSIGNED);
    set_reg(pvag_pkg::REG_THRESHOLD, 32'h1_ffff);
    push_item(pvag_pkg::CMD_SAMPLE, 32'hffff_ffff, 1'b1);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_0000, 1'b1);
    set_reg(pvag_pkg::REG_SIZE, SIZE_UNSUPPORTED);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_1234, 1'b1);
    set_reg(pvag_pkg::REG_SIZE, pvag_pkg::SIZE_16);
    set_reg(pvag_pkg::REG_KIND, pvag_pkg::KIND_FLOAT);
    push_item(pvag_pkg::CMD_SAMPLE, 32'h0000_7fff, 1'b1);
    set_reg(pvag_pkg::REG_KIND, KIND_UNSUPPORTED);
    push_item(pvag_pkg::CMD_SAMPLE, 32'hffff_ffff, 1'b1);

    for (p = 0; p < 9; p++) begin
      wait_idle();
      src_idle_pct = (p < 3) ? 38 : (p < 6) ? 47 : 0;
      snk_idle_pct = (p < 3) ? 47 : (p < 6) ? 38 : 0;
      if (p == 5) set_reg(pvag_pkg::REG_ENABLE, 32'd0);
      set_reg(pvag_pkg::REG_ENABLE, 32'd1);
      set_reg(pvag_pkg::REG_SIZE, (p == 2) ? pvag_pkg::SIZE_32 : 32'($urandom_range(0, 2)));
      if (p == 2) set_reg(pvag_pkg::REG_KIND, pvag_pkg::KIND_FLOAT);
      else if (cfg_size == pvag_pkg::SIZE_32) set_reg(pvag_pkg::REG_KIND, $urandom_range(0, 2));
      else set_reg(pvag_pkg::REG_KIND, $urandom_range(0, 1));
      set_reg(pvag_pkg::REG_BIG_END, $urandom_range(0, 1));
      set_reg(pvag_pkg::REG_THRESHOLD, (p == 0) ? 32'd0 : (p == 1) ? 32'd65536 :
                                       (p == 2) ? 32'h1_ffff : 32'($urandom_range(0, 65536)));
      set_reg(pvag_pkg::REG_TIMEOUT, (p == 3) ? 32'd0 : (p == 4) ? 32'hffff_ffff :
                                     32'($urandom_range(0, 24)));
      gen_traffic(70);
      // sender holds off until every pending result is out
      if (p == 4) wait_idle();
      gen_traffic(70);
    end

    wait_idle();
    if (errors == 0) begin
      $display("PASS packet_peak_voice_activity_gate_unit");
    end else begin
      $display("FAIL packet_peak_voice_activity_gate_unit");
    end
    $finish;
  end

endmodule
